@@ design/mrpt_pkg.sv @@
// Package for the Miller-Rabin prime test unit.
// Holds the default width, the small-prime list and the witness list.
// No dependencies.
`timescale 1ns / 1ps

package mrpt_pkg;

    // default candidate width
    localparam int DATA_WIDTH_DEF = 64;

    // primes up to 37, used for the short list and for trial division
    localparam int NUM_SMALL = 12;
    localparam logic [5:0] SMALL_PRIMES [NUM_SMALL] = '{
        6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13,
        6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
    };

    // fixed witnesses for the strong rounds
    localparam int NUM_WIT = 5;
    localparam logic [3:0] WITNESSES [NUM_WIT] = '{4'd2, 4'd3, 4'd5, 4'd7, 4'd11};

    // candidates at or below this are answered from the list
    localparam int SMALL_LIMIT = 40;

endpackage

@@ design/miller_rabin_prime_test_unit.sv @@
// Channel   Dir   Signals                     Payload
// input     in    i_valid / o_stall           i_number  (DATA_WIDTH bits)
// output    out   o_valid / i_stall           o_is_prime (1 bit)
//
// An item goes through trial division, then the split of n-1 into an odd
// part and a power of two, then per witness about 2*log2(n) modular
// products in the shared multiplier. Candidates up to 40 or caught by
// trial division are answered after trial division alone. Reset is
// synchronous, active low, and needs no clearing pass. o_stall is high
// while an item is in work; a held result does not block the next item.
// Top level, uses mrpt_pkg, mrpt_sieve and mrpt_modmul.
`timescale 1ns / 1ps

module miller_rabin_prime_test_unit
    import mrpt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DATA_WIDTH-1:0] i_number,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_is_prime
);

    localparam int CW = $clog2(DATA_WIDTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SIEVE = 3'd1;
    localparam logic [2:0] S_SPLIT = 3'd2;
    localparam logic [2:0] S_POW   = 3'd3;
    localparam logic [2:0] S_MULR  = 3'd4;
    localparam logic [2:0] S_MULB  = 3'd5;
    localparam logic [2:0] S_TEST  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]            r_state;
    logic                  r_sqr;
    logic                  r_first;
    logic                  r_result;
    logic                  r_ovalid;
    logic                  r_oprime;
    logic [2:0]            r_wi;
    logic [CW-1:0]         r_k;
    logic [CW-1:0]         r_j;
    logic [DATA_WIDTH-1:0] r_n;
    logic [DATA_WIDTH-1:0] r_m;
    logic [DATA_WIDTH-1:0] r_e;
    logic [DATA_WIDTH-1:0] r_r;
    logic [DATA_WIDTH-1:0] r_base;

    logic                  w_in_acc;
    logic                  w_sv_start;
    logic                  w_sv_done;
    logic                  w_sv_div;
    logic                  w_mm_start;
    logic [DATA_WIDTH-1:0] w_mm_a;
    logic [DATA_WIDTH-1:0] w_mm_b;
    logic                  w_mm_done;
    logic [DATA_WIDTH-1:0] w_mm_res;
    logic                  w_small_hit;
    logic                  w_pass;
    logic                  w_out_free;
    logic [DATA_WIDTH-1:0] w_nm1;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_sv_start = w_in_acc;
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_nm1      = r_n - 1'b1;

    // candidate on the short list of primes
    always_comb begin
        w_small_hit = 1'b0;
        for (int i = 0; i < NUM_SMALL; i++) begin
            if (r_n == DATA_WIDTH'(SMALL_PRIMES[i])) begin
                w_small_hit = 1'b1;
            end
        end
    end

    // strong-round exit on n-1, or on 1 before any squaring
    assign w_pass = (r_r == w_nm1) || (r_first && r_r == DATA_WIDTH'(1));

    // multiplier start and operand select
    always_comb begin
        w_mm_start = 1'b0;
        w_mm_a     = r_base;
        w_mm_b     = r_base;
        unique case (r_state)
            S_POW: begin
                if (r_e != '0) begin
                    w_mm_start = 1'b1;
                    if (r_e[0]) begin
                        w_mm_a = r_r;
                    end
                end
            end
            S_MULR: begin
                w_mm_start = w_mm_done;
            end
            S_TEST: begin
                w_mm_start = !w_pass && (r_j < r_k);
                w_mm_a     = r_r;
                w_mm_b     = r_r;
            end
            default: begin
                w_mm_start = 1'b0;
            end
        endcase
    end

    mrpt_sieve #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_sieve (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_sv_start),
        .i_number    (i_number),
        .o_done      (w_sv_done),
        .o_divisible (w_sv_div)
    );

    mrpt_modmul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mm_start),
        .i_a      (w_mm_a),
        .i_b      (w_mm_b),
        .i_n      (r_n),
        .o_done   (w_mm_done),
        .o_result (w_mm_res)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_SIEVE;
                    end
                end
                S_SIEVE: begin
                    r_m <= w_nm1;
                    r_k <= '0;
                    if (w_sv_done) begin
                        if (r_n <= DATA_WIDTH'(SMALL_LIMIT)) begin
                            r_result <= w_small_hit;
                            r_state  <= S_DONE;
                        end else if (w_sv_div) begin
                            r_result <= 1'b0;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SPLIT;
                        end
                    end
                end
                S_SPLIT: begin
                    if (!r_m[0]) begin
                        r_m <= r_m >> 1;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_wi    <= 3'd0;
                        r_r     <= DATA_WIDTH'(1);
                        r_base  <= DATA_WIDTH'(WITNESSES[0]);
                        r_e     <= r_m;
                        r_j     <= CW'(1);
                        r_first <= 1'b1;
                        r_state <= S_POW;
                    end
                end
                S_POW: begin
                    if (r_e == '0) begin
                        r_state <= S_TEST;
                    end else if (r_e[0]) begin
                        r_state <= S_MULR;
                    end else begin
                        r_state <= S_MULB;
                    end
                end
                S_MULR: begin
                    if (w_mm_done) begin
                        r_r     <= w_mm_res;
                        r_state <= S_MULB;
                    end
                end
                S_MULB: begin
                    if (w_mm_done) begin
                        if (r_sqr) begin
                            r_r     <= w_mm_res;
                            r_j     <= r_j + 1'b1;
                            r_first <= 1'b0;
                            r_state <= S_TEST;
                        end else begin
                            r_base  <= w_mm_res;
                            r_e     <= r_e >> 1;
                            r_state <= S_POW;
                        end
                    end
                end
                S_TEST: begin
                    if (w_pass) begin
                        if (r_wi == 3'(NUM_WIT - 1)) begin
                            r_result <= 1'b1;
                            r_state  <= S_DONE;
                        end else begin
                            r_wi    <= r_wi + 1'b1;
                            r_r     <= DATA_WIDTH'(1);
                            r_base  <= DATA_WIDTH'(WITNESSES[r_wi + 1'b1]);
                            r_e     <= r_m;
                            r_j     <= CW'(1);
                            r_first <= 1'b1;
                            r_state <= S_POW;
                        end
                    end else if (r_j >= r_k) begin
                        r_result <= 1'b0;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_MULB;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_ovalid <= 1'b1;
            r_oprime <= r_result;
        end else if (r_ovalid && !i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // item capture and squaring-phase flag
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_n <= i_number;
        end
        if (r_state == S_POW) begin
            r_sqr <= 1'b0;
        end else if (r_state == S_TEST) begin
            r_sqr <= 1'b1;
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_is_prime = r_oprime;

endmodule

@@ design/mrpt_modmul.sv @@
// Shared modular multiplier: (a * b) mod n by shift-and-add, msb first.
// Each bit of b takes a double step, then a conditional add step. Uses mrpt_pkg.
`timescale 1ns / 1ps

module mrpt_modmul
    import mrpt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    input  logic [DATA_WIDTH-1:0] i_n,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_result
);

    localparam int CW = $clog2(DATA_WIDTH);

    // (x + y) mod n for x, y below n
    function automatic logic [DATA_WIDTH-1:0] add_mod(
        input logic [DATA_WIDTH-1:0] x,
        input logic [DATA_WIDTH-1:0] y,
        input logic [DATA_WIDTH-1:0] n
    );
        logic [DATA_WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, n}) begin
            s = s - {1'b0, n};
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    logic                  r_busy;
    logic                  r_phase;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_x;
    logic [DATA_WIDTH-1:0] r_y;
    logic [DATA_WIDTH-1:0] r_n;
    logic [DATA_WIDTH-1:0] n_acc;

    // one add-and-reduce per cycle
    always_comb begin
        if (!r_phase) begin
            n_acc = add_mod(r_acc, r_acc, r_n);
        end else if (r_y[DATA_WIDTH-1]) begin
            n_acc = add_mod(r_acc, r_x, r_n);
        end else begin
            n_acc = r_acc;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    if (r_cnt == CW'(DATA_WIDTH - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_a;
            r_y   <= i_b;
            r_n   <= i_n;
        end else if (r_busy) begin
            r_acc <= n_acc;
            if (r_phase) begin
                r_y <= {r_y[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

@@ design/mrpt_sieve.sv @@
// Trial division by the primes up to 37, one candidate bit per cycle.
// Twelve residue lanes run side by side. Uses mrpt_pkg.
`timescale 1ns / 1ps

module mrpt_sieve
    import mrpt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_number,
    output logic                  o_done,
    output logic                  o_divisible
);

    localparam int CW = $clog2(DATA_WIDTH);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [DATA_WIDTH-1:0] r_shift;
    logic [5:0]            r_res [NUM_SMALL];
    logic [5:0]            n_res [NUM_SMALL];
    logic [6:0]            w_t   [NUM_SMALL];
    logic                  w_zero;

    // residue update: r = (2r + bit) mod p, one compare-subtract
    always_comb begin
        w_zero = 1'b0;
        for (int i = 0; i < NUM_SMALL; i++) begin
            w_t[i] = {r_res[i], r_shift[DATA_WIDTH-1]};
            if (w_t[i] >= {1'b0, SMALL_PRIMES[i]}) begin
                n_res[i] = 6'(w_t[i] - {1'b0, SMALL_PRIMES[i]});
            end else begin
                n_res[i] = w_t[i][5:0];
            end
            if (r_res[i] == 6'd0) begin
                w_zero = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(DATA_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // residue lanes
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_number;
            for (int i = 0; i < NUM_SMALL; i++) begin
                r_res[i] <= 6'd0;
            end
        end else if (r_busy) begin
            r_shift <= {r_shift[DATA_WIDTH-2:0], 1'b0};
            for (int i = 0; i < NUM_SMALL; i++) begin
                r_res[i] <= n_res[i];
            end
        end
    end

    assign o_done      = r_done;
    assign o_divisible = w_zero;

endmodule

@@ design/mrpt_checker.sv @@
// Port-level checks for the Miller-Rabin prime test unit, bound to the top.
// Depends on miller_rabin_prime_test_unit ports only.
`timescale 1ns / 1ps

module mrpt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_is_prime
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_is_prime)))
        else $error("result changed while stalled");

    // an accepted item puts the unit in work
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("no busy after accepted item");

    // a new result coincides with the unit going free
    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("result shown while still busy");

    // reset leaves the unit empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("unit not empty after reset");

endmodule

bind miller_rabin_prime_test_unit mrpt_checker u_mrpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_is_prime (o_is_prime)
);
